FILE: hw/rtl/kte_pkg.sv
package kte_pkg;

  localparam int SYM_W         = 8;
  localparam int IDX_W         = 5;
  localparam int TOKEN_W       = 60;
  localparam int SIZE_W        = 6;
  localparam int KLEN_W        = 4;
  localparam int CFG_W         = 64;
  localparam int CFG_ADDR_W    = 3;
  localparam int NUM_CHAR_REGS = 4;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_CHARS_LO   = 3'd0,
    REG_CHARS_MID  = 3'd1,
    REG_CHARS_HIGH = 3'd2,
    REG_CHARS_TOP  = 3'd3,
    REG_ALPH_SIZE  = 3'd4,
    REG_KMER_LEN   = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DONE
  } kte_state_e;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } kte_in_t;

  typedef struct packed {
    logic [TOKEN_W-1:0] token;
    logic               unknown_seen;
    logic               last_token;
  } kte_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic calc_step;
    logic load_out;
  } kte_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit;
    logic last_step;
    logic out_free;
  } kte_status_t;

endpackage

FILE: hw/rtl/kte_controller.sv
module kte_controller
  import kte_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  kte_status_t status_i,
  output logic        in_stall_o,
  output kte_cmd_t    cmd_o
);

  kte_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          if (status_i.emit) begin
            state_d = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        cmd_o.calc_step = 1'b1;
        if (status_i.last_step) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/kte_datapath.sv
module kte_datapath
  import kte_pkg::*;
#(
  parameter int K_MAX        = 12,
  parameter int ALPHABET_MAX = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  kte_in_t               in_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output kte_out_t              out_o,
  input  kte_cmd_t              cmd_i,
  output kte_status_t           status_o
);

  localparam int CNT_W = $clog2(K_MAX + 1);

  logic [CFG_W-1:0]  chars_q [NUM_CHAR_REGS];
  logic [SIZE_W-1:0] alph_size_q;
  logic [KLEN_W-1:0] kmer_len_q;

  logic [IDX_W-1:0]   win_idx_q [K_MAX];
  logic               win_unk_q [K_MAX];
  logic [CNT_W-1:0]   fill_q;
  logic               last_q;
  logic [TOKEN_W-1:0] acc_q;
  logic [CNT_W-1:0]   step_q;
  kte_out_t           out_q;
  logic               out_valid_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_CHAR_REGS; r++) begin
        chars_q[r] <= '0;
      end
      alph_size_q <= SIZE_W'(4);
      kmer_len_q  <= KLEN_W'(3);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_CHARS_LO:   chars_q[0]  <= cfg_wdata_i;
        REG_CHARS_MID:  chars_q[1]  <= cfg_wdata_i;
        REG_CHARS_HIGH: chars_q[2]  <= cfg_wdata_i;
        REG_CHARS_TOP:  chars_q[3]  <= cfg_wdata_i;
        REG_ALPH_SIZE:  alph_size_q <= cfg_wdata_i[SIZE_W-1:0];
        REG_KMER_LEN:   kmer_len_q  <= cfg_wdata_i[KLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Effective base and window length after clamping.
  logic [SIZE_W-1:0] a_eff;
  logic [CNT_W-1:0]  k_eff;

  always_comb begin
    if (alph_size_q == '0) begin
      a_eff = SIZE_W'(1);
    end else if (int'(alph_size_q) > ALPHABET_MAX) begin
      a_eff = SIZE_W'(ALPHABET_MAX);
    end else begin
      a_eff = alph_size_q;
    end
    if (kmer_len_q == '0) begin
      k_eff = CNT_W'(1);
    end else if (int'(kmer_len_q) > K_MAX) begin
      k_eff = CNT_W'(K_MAX);
    end else begin
      k_eff = CNT_W'(kmer_len_q);
    end
  end

  // Symbol lookup: parallel compares, lowest matching index wins.
  logic [NUM_CHAR_REGS*CFG_W-1:0] all_codes;
  logic [SYM_W-1:0]               codes [ALPHABET_MAX];
  logic [IDX_W-1:0]               lk_idx;
  logic                           lk_found;

  assign all_codes = {chars_q[3], chars_q[2], chars_q[1], chars_q[0]};

  for (genvar g = 0; g < ALPHABET_MAX; g++) begin : g_codes
    assign codes[g] = all_codes[g*SYM_W +: SYM_W];
  end

  always_comb begin
    lk_idx   = '0;
    lk_found = 1'b0;
    for (int i = ALPHABET_MAX - 1; i >= 0; i--) begin
      if ((i < int'(a_eff)) && (codes[i] == in_i.symbol)) begin
        lk_idx   = IDX_W'(i);
        lk_found = 1'b1;
      end
    end
  end

  // Fill count after this item and whether it produces a token.
  logic [CNT_W-1:0] fill_inc;
  assign fill_inc = (fill_q < CNT_W'(K_MAX)) ? fill_q + 1'b1 : fill_q;

  // Horner step operand and accumulate.
  logic [IDX_W-1:0]   w_sel;
  logic [TOKEN_W-1:0] prod;
  logic               unk_any;

  always_comb begin
    w_sel   = '0;
    unk_any = 1'b0;
    for (int j = 0; j < K_MAX; j++) begin
      if (CNT_W'(j) == step_q) begin
        w_sel = win_idx_q[j];
      end
      if (j < int'(k_eff)) begin
        unk_any = unk_any | win_unk_q[j];
      end
    end
  end

  assign prod = acc_q * TOKEN_W'(a_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < K_MAX; j++) begin
        win_idx_q[j] <= '0;
        win_unk_q[j] <= 1'b0;
      end
      fill_q <= '0;
      last_q <= 1'b0;
      step_q <= '0;
    end else if (cmd_i.load_item) begin
      last_q <= in_i.last;
      step_q <= '0;
      if (in_i.last && (fill_inc < k_eff)) begin
        // A short sequence ends here without a token.
        for (int j = 0; j < K_MAX; j++) begin
          win_idx_q[j] <= '0;
          win_unk_q[j] <= 1'b0;
        end
        fill_q <= '0;
      end else begin
        for (int j = K_MAX - 1; j > 0; j--) begin
          win_idx_q[j] <= win_idx_q[j-1];
          win_unk_q[j] <= win_unk_q[j-1];
        end
        win_idx_q[0] <= lk_idx;
        win_unk_q[0] <= ~lk_found;
        fill_q       <= fill_inc;
      end
    end else if (cmd_i.calc_step) begin
      step_q <= step_q + 1'b1;
    end else if (cmd_i.load_out && last_q) begin
      for (int j = 0; j < K_MAX; j++) begin
        win_idx_q[j] <= '0;
        win_unk_q[j] <= 1'b0;
      end
      fill_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      acc_q <= '0;
    end else if (cmd_i.calc_step) begin
      acc_q <= prod + TOKEN_W'(w_sel);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.token        <= acc_q;
      out_q.unknown_seen <= unk_any;
      out_q.last_token   <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign status_o.emit      = fill_inc >= k_eff;
  assign status_o.last_step = step_q == (k_eff - 1'b1);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

FILE: hw/rtl/kmer_token_encoder.sv
// K-mer token encoder.
// Requests on the input channel carry one character of a sequence and a last flag;
// a request is taken at a clock edge where in_valid_i is high and in_stall_o is low.
// Each character is looked up in the configured alphabet, shifted into a window of
// the last k indices, and once k characters of the sequence have arrived the block
// emits one token request on the output channel (out_valid_o / out_stall_i).
// A character that produces no token leaves the block idle. A character that
// produces a token is taken, then runs the Horner loop (one multiply-add by the
// alphabet size per window position), then loads the output register once it is
// free, so the window length sets the rate. Reset restores alphabet size 4, window
// length 3, zero character codes and an empty window. If the receiver stalls, the
// finished token waits in the output register while the next character is accepted
// and computed; the block then holds that result internally and stalls its input
// until the output register frees up. The user must write configuration only while
// idle, through cfg_we_i / cfg_addr_i / cfg_wdata_i; the block never enforces it.
module kmer_token_encoder
  import kte_pkg::*;
#(
  parameter int K_MAX        = 12,
  parameter int ALPHABET_MAX = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  kte_in_t               in_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output kte_out_t              out_o
);

  kte_cmd_t    cmd;
  kte_status_t status;

  // The controller sequences accept, the Horner iterations and the output load.
  kte_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // The datapath holds the configuration, the window, the accumulator and the
  // output register.
  kte_datapath #(
    .K_MAX        (K_MAX),
    .ALPHABET_MAX (ALPHABET_MAX)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  // A result is never loaded over one that the receiver has not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> status.out_free)
    else $error("output register overwritten");

  // The Horner loop stops right after its final step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.calc_step && status.last_step) |=> !cmd.calc_step)
    else $error("Horner loop ran past window length");

  // New characters are only taken while no computation is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.calc_step || cmd.load_out) |-> in_stall_o)
    else $error("input accepted during computation");

  // Loading the output register always hands a valid result to the receiver.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> out_valid_o)
    else $error("loaded result not presented");

endmodule
